// ===== sv/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slbm_pkg
// Types, codes and constants shared by the serial loaded bank mapper.
// ----------------------------------------------------------------------------
package slbm_pkg;

  localparam int OFFSET_W    = 19;
  localparam int CHR_SPAN_W  = 17;
  localparam int BANK_W      = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam int PRG_OFFSET_BITS_DEFAULT = 19;
  localparam int CHR_OFFSET_BITS_DEFAULT = 17;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PRG   = 2'd1;
  localparam logic [1:0] CMD_CHR   = 2'd2;

  localparam logic [2:0] LOAD_NONE    = 3'd0;
  localparam logic [2:0] LOAD_CONTROL = 3'd1;
  localparam logic [2:0] LOAD_CHR0    = 3'd2;
  localparam logic [2:0] LOAD_CHR1    = 3'd3;
  localparam logic [2:0] LOAD_PRG     = 3'd4;

  localparam logic [1:0] TARGET_CONTROL = 2'd0;
  localparam logic [1:0] TARGET_CHR0    = 2'd1;
  localparam logic [1:0] TARGET_CHR1    = 2'd2;
  localparam logic [1:0] TARGET_PRG     = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_MASK       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_MASK       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_PRESENT    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_MIRROR = 2'd3;

  localparam logic [BANK_W-1:0] PRG_MASK_RESET    = 5'd1;
  localparam logic [BANK_W-1:0] CHR_MASK_RESET    = 5'd1;
  localparam logic              CHR_PRESENT_RESET = 1'b1;
  localparam logic [1:0]        MIRROR_RESET      = 2'd2;
  localparam logic [BANK_W-1:0] PRG_MODE3_BITS    = 5'b01100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] rom_offset;
    logic                ram_write;
    logic [2:0]          loaded_register;
    logic [1:0]          mirroring;
  } out_item_t;

  typedef struct packed {
    logic [BANK_W-1:0] control;
    logic [BANK_W-1:0] chr_low;
    logic [BANK_W-1:0] chr_high;
    logic [BANK_W-1:0] prg_page;
    logic [BANK_W-1:0] prg_mask;
    logic [BANK_W-1:0] chr_mask;
    logic              chr_present;
  } map_state_t;

endpackage

// ===== sv/serial_loaded_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Cartridge bank mapper with a five-bit serial loader and live lookups.
// ----------------------------------------------------------------------------
// in_valid/in_ready/in_item carry bus accesses: CPU writes, PRG lookups and
// CHR lookups. out_valid/out_ready/out_item return one result per access, in
// order: the ROM byte offset, the work RAM write strobe, the register that a
// fifth serial write loaded and the mirroring field after the access.
// cfg_wen/cfg_index/cfg_data write the bank masks and the CHR ROM flag; a
// write to the initial mirroring register has no effect, reset always takes
// the default mirroring field.
// An accepted access is held in an input register; when it moves on, it is
// translated and the banking state is updated together, and its result is
// captured in the result register, from which it leaves on out_ready.
// The block takes one access every cycle while the receiver keeps up; the
// input register and the result register decouple the two channels, so a
// stalled receiver fills both and then drops in_ready.
// Synchronous reset empties both registers, clears the loader and banks, and
// sets control to PRG mode 3, CHR mode 0 with the reset mirroring field.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper #(
  parameter int PRG_OFFSET_BITS = slbm_pkg::PRG_OFFSET_BITS_DEFAULT,
  parameter int CHR_OFFSET_BITS = slbm_pkg::CHR_OFFSET_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  slbm_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output slbm_pkg::out_item_t                out_item,
  input  logic                               cfg_wen,
  input  logic [slbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                              hold_valid;
  slbm_pkg::in_item_t                hold_item;
  logic                              advance;
  slbm_pkg::map_state_t              state;
  logic                              ram_write;
  logic [2:0]                        loaded_register;
  logic [1:0]                        mirroring;
  logic [slbm_pkg::OFFSET_W-1:0]     rom_offset;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_item <= in_item;
    end
  end

  slbm_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .step            (advance),
    .item            (hold_item),
    .state           (state),
    .ram_write       (ram_write),
    .loaded_register (loaded_register),
    .mirroring       (mirroring)
  );

  slbm_xlate #(
    .PRG_OFFSET_BITS (PRG_OFFSET_BITS),
    .CHR_OFFSET_BITS (CHR_OFFSET_BITS)
  ) u_xlate (
    .item       (hold_item),
    .state      (state),
    .rom_offset (rom_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register, loaded on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.rom_offset      <= rom_offset;
      out_item.ram_write       <= ram_write;
      out_item.loaded_register <= loaded_register;
      out_item.mirroring       <= mirroring;
    end
  end

endmodule

// ===== sv/slbm_regs.sv =====
// ----------------------------------------------------------------------------
// slbm_regs
// Configuration registers, serial loader and banking registers.
// ----------------------------------------------------------------------------
module slbm_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [slbm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [slbm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   step,
  input  slbm_pkg::in_item_t                     item,
  output slbm_pkg::map_state_t                   state,
  output logic                                   ram_write,
  output logic [2:0]                             loaded_register,
  output logic [1:0]                             mirroring
);

  logic [slbm_pkg::BANK_W-1:0] prg_mask;
  logic [slbm_pkg::BANK_W-1:0] chr_mask;
  logic                        chr_present;

  logic [slbm_pkg::BANK_W-1:0] shift_value, shift_value_next;
  logic [2:0]                  shift_count, shift_count_next;
  logic [slbm_pkg::BANK_W-1:0] control, control_next;
  logic [slbm_pkg::BANK_W-1:0] chr_low, chr_low_next;
  logic [slbm_pkg::BANK_W-1:0] chr_high, chr_high_next;
  logic [slbm_pkg::BANK_W-1:0] prg_page, prg_page_next;

  logic                        is_write;
  logic                        in_ram;
  logic                        in_rom;
  logic [slbm_pkg::BANK_W-1:0] shift_merged;

  assign is_write     = (item.cmd == slbm_pkg::CMD_WRITE);
  assign in_ram       = (item.address[15:13] == 3'b011);
  assign in_rom       = item.address[15];
  assign shift_merged = shift_value
                      | (slbm_pkg::BANK_W'(item.value[0]) << shift_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_mask    <= slbm_pkg::PRG_MASK_RESET;
      chr_mask    <= slbm_pkg::CHR_MASK_RESET;
      chr_present <= slbm_pkg::CHR_PRESENT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        slbm_pkg::CFG_PRG_MASK:       prg_mask    <= cfg_data;
        slbm_pkg::CFG_CHR_MASK:       chr_mask    <= cfg_data;
        slbm_pkg::CFG_CHR_PRESENT:    chr_present <= cfg_data[0];
        // initial mirror writes are ignored; reset seeds control from MIRROR_RESET
        slbm_pkg::CFG_INITIAL_MIRROR: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_value_next = shift_value;
    shift_count_next = shift_count;
    control_next     = control;
    chr_low_next     = chr_low;
    chr_high_next    = chr_high;
    prg_page_next    = prg_page;
    loaded_register  = slbm_pkg::LOAD_NONE;
    if (is_write && in_rom) begin
      if (item.value[7]) begin
        shift_value_next = '0;
        shift_count_next = '0;
        control_next     = control | slbm_pkg::PRG_MODE3_BITS;
      end else if (shift_count == 3'd4) begin
        shift_value_next = '0;
        shift_count_next = '0;
        case (item.address[14:13])
          slbm_pkg::TARGET_CONTROL: begin
            control_next    = shift_merged;
            loaded_register = slbm_pkg::LOAD_CONTROL;
          end
          slbm_pkg::TARGET_CHR0: begin
            chr_low_next    = shift_merged;
            loaded_register = slbm_pkg::LOAD_CHR0;
          end
          slbm_pkg::TARGET_CHR1: begin
            chr_high_next   = shift_merged;
            loaded_register = slbm_pkg::LOAD_CHR1;
          end
          default: begin
            prg_page_next   = shift_merged;
            loaded_register = slbm_pkg::LOAD_PRG;
          end
        endcase
      end else begin
        shift_value_next = shift_merged;
        shift_count_next = shift_count + 3'd1;
      end
    end
  end

  assign ram_write = is_write && in_ram;
  assign mirroring = control_next[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value <= '0;
      shift_count <= '0;
      control     <= slbm_pkg::PRG_MODE3_BITS
                   | slbm_pkg::BANK_W'(slbm_pkg::MIRROR_RESET);
      chr_low     <= '0;
      chr_high    <= '0;
      prg_page    <= '0;
    end else if (step) begin
      shift_value <= shift_value_next;
      shift_count <= shift_count_next;
      control     <= control_next;
      chr_low     <= chr_low_next;
      chr_high    <= chr_high_next;
      prg_page    <= prg_page_next;
    end
  end

  always_comb begin
    state.control     = control;
    state.chr_low     = chr_low;
    state.chr_high    = chr_high;
    state.prg_page    = prg_page;
    state.prg_mask    = prg_mask;
    state.chr_mask    = chr_mask;
    state.chr_present = chr_present;
  end

endmodule

// ===== sv/slbm_xlate.sv =====
// ----------------------------------------------------------------------------
// slbm_xlate
// PRG and CHR address translation from the current banking state.
// ----------------------------------------------------------------------------
module slbm_xlate #(
  parameter int PRG_OFFSET_BITS = slbm_pkg::PRG_OFFSET_BITS_DEFAULT,
  parameter int CHR_OFFSET_BITS = slbm_pkg::CHR_OFFSET_BITS_DEFAULT
) (
  input  slbm_pkg::in_item_t                 item,
  input  slbm_pkg::map_state_t               state,
  output logic [slbm_pkg::OFFSET_W-1:0]      rom_offset
);

  localparam logic [slbm_pkg::OFFSET_W-1:0] PRG_KEEP =
    slbm_pkg::OFFSET_W'((64'd1 << PRG_OFFSET_BITS) - 64'd1);
  localparam logic [slbm_pkg::CHR_SPAN_W-1:0] CHR_KEEP =
    slbm_pkg::CHR_SPAN_W'((64'd1 << CHR_OFFSET_BITS) - 64'd1);

  logic [1:0]                          prg_mode;
  logic [3:0]                          prg_sel;
  logic [slbm_pkg::BANK_W-1:0]         prg_page16;
  logic [slbm_pkg::OFFSET_W-1:0]       prg_off;
  logic [12:0]                         chr_addr;
  logic [slbm_pkg::BANK_W-1:0]         chr_low_m;
  logic [slbm_pkg::BANK_W-1:0]         chr_bank4k;
  logic [slbm_pkg::CHR_SPAN_W-1:0]     chr_off;
  logic [slbm_pkg::OFFSET_W-1:0]       chr_final;

  assign prg_mode  = state.control[3:2];
  assign prg_sel   = state.prg_page[3:0] & state.prg_mask[3:0];
  assign chr_addr  = item.address[12:0];
  assign chr_low_m = state.chr_low & state.chr_mask;
  assign chr_bank4k = (chr_addr[12] ? state.chr_high : state.chr_low) & state.chr_mask;

  always_comb begin
    prg_page16 = '0;
    if (!item.address[14]) begin
      prg_page16 = (prg_mode == slbm_pkg::PRG_MODE_FIX_LOW) ? '0 : {1'b0, prg_sel};
    end else begin
      prg_page16 = (prg_mode == slbm_pkg::PRG_MODE_FIX_LOW) ? {1'b0, prg_sel}
                                                           : state.prg_mask;
    end
    if (!item.address[15]) begin
      prg_off = '0;
    end else if (!prg_mode[1]) begin
      prg_off = {1'b0, prg_sel[3:1], item.address[14:0]} & PRG_KEEP;
    end else begin
      prg_off = {prg_page16, item.address[13:0]} & PRG_KEEP;
    end
  end

  always_comb begin
    if (!state.control[4]) begin
      chr_off = {chr_low_m[4:1], chr_addr} & CHR_KEEP;
    end else begin
      chr_off = {chr_bank4k, chr_addr[11:0]} & CHR_KEEP;
    end
    if (!state.chr_present) begin
      chr_final = slbm_pkg::OFFSET_W'(chr_addr);
    end else begin
      chr_final = slbm_pkg::OFFSET_W'(chr_off);
    end
  end

  always_comb begin
    case (item.cmd)
      slbm_pkg::CMD_PRG: rom_offset = prg_off;
      slbm_pkg::CMD_CHR: rom_offset = chr_final;
      default:           rom_offset = '0;
    endcase
  end

endmodule
